// ===== hw/rtl/msgd_pkg.sv =====
// -----------------------------------------------------------------------------
// msgd_pkg
// Types, codes and helpers shared by the momentum SGD gain update block.
// -----------------------------------------------------------------------------
package msgd_pkg;

   // item actions
   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_GRAD    = 2'd1;
   localparam logic [1:0] ACT_READ    = 2'd2;
   localparam logic [1:0] ACT_RESTART = 2'd3;

   // register indexes
   localparam logic [2:0] CSR_LEARNING_RATE  = 3'd0;
   localparam logic [2:0] CSR_RATE_DECAY     = 3'd1;
   localparam logic [2:0] CSR_RATE_FLOOR     = 3'd2;
   localparam logic [2:0] CSR_MOMENTUM_START = 3'd3;
   localparam logic [2:0] CSR_MOMENTUM_STEP  = 3'd4;
   localparam logic [2:0] CSR_MOMENTUM_CAP   = 3'd5;
   localparam logic [2:0] CSR_GAIN_LOW       = 3'd6;
   localparam logic [2:0] CSR_GAIN_HIGH      = 3'd7;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 24;
   localparam int INDEX_W   = 10;

   localparam logic [23:0] ONE_Q16  = 24'd65536;
   localparam logic [23:0] GAIN_ADD = 24'd3277;
   localparam logic [15:0] GAIN_MUL = 16'd62259;
   localparam logic [23:0] GAIN_MAX = 24'hFFFFFF;
   localparam logic [16:0] Q17_MAX  = 17'h1FFFF;

   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic [1:0]         action;
      logic [9:0]         index;
      logic signed [31:0] value;
      logic               is_last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] weight_out;
      logic signed [31:0] lookahead_out;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] weight;
      logic signed [31:0] velocity;
      logic [23:0]        gain;
   } entry_type;

   function automatic logic signed [31:0] sat32(input logic signed [57:0] x);
      logic signed [31:0] r;
      if (x > 58'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (x < -58'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/msgd_mul.sv =====
// -----------------------------------------------------------------------------
// msgd_mul
// Shared signed multiplier with a registered product.
// -----------------------------------------------------------------------------
module msgd_mul (
   input  logic                                   clock,
   input  logic signed [msgd_pkg::MUL_A_W-1:0]    mul_a,
   input  logic signed [msgd_pkg::MUL_B_W-1:0]    mul_b,
   output logic signed [msgd_pkg::PROD_W-1:0]     prod
);

   logic signed [msgd_pkg::PROD_W-1:0] prod_ff;
   logic signed [msgd_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = msgd_pkg::PROD_W'(mul_a) * msgd_pkg::PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/msgd_store.sv =====
// -----------------------------------------------------------------------------
// msgd_store
// Per-weight memory: weight, velocity and gain, one write and one read port.
// -----------------------------------------------------------------------------
module msgd_store #(
   parameter int NUM_WEIGHTS = 1024,
   parameter int AW          = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  msgd_pkg::entry_type   wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output msgd_pkg::entry_type   rd_data
);

   msgd_pkg::entry_type mem [NUM_WEIGHTS];
   msgd_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/momentum_sgd_gain_update.sv =====
// -----------------------------------------------------------------------------
// momentum_sgd_gain_update
// Momentum SGD with per-weight adaptive gains, Q16.16 fixed point.
// -----------------------------------------------------------------------------
//  channel  ports               direction  contents
//  req      req_valid/ready     in         action, index, value, is_last
//  rsp      rsp_valid/ready     out        weight_out, lookahead_out
//  csr      csr_we/index/wdata  in         register writes, no read-back
//
// every multiply goes through the one shared multiplier, one product per cycle.
// reset is synchronous and restores the control registers and the schedule; the
// weight memory is not cleared. a new item is taken while the previous result
// still waits on rsp_ready; the sequencer holds its last step until it drains.
// -----------------------------------------------------------------------------
module momentum_sgd_gain_update #(
   parameter int NUM_WEIGHTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  msgd_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output msgd_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [msgd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [msgd_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_FETCH    = 4'd1;
   localparam logic [3:0] S_GAIN_MUL = 4'd2;
   localparam logic [3:0] S_GAIN     = 4'd3;
   localparam logic [3:0] S_GSCALE   = 4'd4;
   localparam logic [3:0] S_GSAT     = 4'd5;
   localparam logic [3:0] S_MV       = 4'd6;
   localparam logic [3:0] S_RG       = 4'd7;
   localparam logic [3:0] S_DIFF     = 4'd8;
   localparam logic [3:0] S_VEL      = 4'd9;
   localparam logic [3:0] S_WGT      = 4'd10;
   localparam logic [3:0] S_RATE_MUL = 4'd11;
   localparam logic [3:0] S_SCHED    = 4'd12;
   localparam logic [3:0] S_LA_MUL   = 4'd13;
   localparam logic [3:0] S_LA       = 4'd14;
   localparam logic [3:0] S_DONE     = 4'd15;

   // control state
   logic [3:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [16:0] learning_rate_ff, learning_rate_in;
   logic [16:0] rate_decay_ff, rate_decay_in;
   logic [16:0] rate_floor_ff, rate_floor_in;
   logic [15:0] momentum_start_ff, momentum_start_in;
   logic [15:0] momentum_step_ff, momentum_step_in;
   logic [16:0] momentum_cap_ff, momentum_cap_in;
   logic [23:0] gain_low_ff, gain_low_in;
   logic [23:0] gain_high_ff, gain_high_in;
   logic [16:0] cur_rate_ff, cur_rate_in;
   logic [16:0] cur_mom_ff, cur_mom_in;

   // item and datapath registers
   logic [1:0]         act_ff, act_in;
   logic               last_ff, last_in;
   logic               ok_ff, ok_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic signed [31:0] g_ff, g_in;
   logic signed [31:0] w_ff, w_in;
   logic signed [31:0] v_ff, v_in;
   logic [23:0]        gn_ff, gn_in;
   logic signed [57:0] acc_ff, acc_in;
   logic signed [31:0] res_w_ff, res_w_in;
   logic signed [31:0] res_l_ff, res_l_in;
   msgd_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic signed [msgd_pkg::MUL_A_W-1:0] mul_a;
   logic signed [msgd_pkg::MUL_B_W-1:0] mul_b;
   logic signed [msgd_pkg::PROD_W-1:0]  prod;
   logic signed [57:0]                  prod_ext;
   logic signed [57:0]                  prod_sh;

   // memory ports
   logic                 st_wr_en;
   logic [AW-1:0]        st_wr_addr;
   msgd_pkg::entry_type  st_wr_data;
   logic                 st_rd_en;
   logic [AW-1:0]        req_addr;
   msgd_pkg::entry_type  st_rd_data;

   logic               req_xfer;
   logic               req_ok;
   logic               gains_on;
   logic               opposite;
   logic [24:0]        gain_sum;
   logic [23:0]        gain_sel;
   logic [23:0]        gain_clamp;
   logic signed [31:0] w_new;
   logic [16:0]        rate_dec;
   logic [16:0]        rate_new;
   logic [17:0]        mom_sum;
   logic [16:0]        mom_sat;
   logic [16:0]        mom_new;

   msgd_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   msgd_store #(
      .NUM_WEIGHTS (NUM_WEIGHTS),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (req_addr),
      .rd_data (st_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign req_ok    = ({22'b0, req_data.index} < 32'(NUM_WEIGHTS));
   assign req_addr  = AW'(req_data.index);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign prod_ext = $signed({prod[msgd_pkg::PROD_W-1], prod});
   assign prod_sh  = prod_ext >>> 16;

   assign gains_on = !((gain_low_ff == msgd_pkg::ONE_Q16) && (gain_high_ff == msgd_pkg::ONE_Q16));
   assign opposite = ((v_ff < 0) && (g_ff > 0)) || ((v_ff > 0) && (g_ff < 0));

   // gain adapt: grow by 0.05 with saturation, or scale by 0.95, then clamp
   always_comb begin
      gain_sum = {1'b0, gn_ff} + {1'b0, msgd_pkg::GAIN_ADD};
      if (opposite) begin
         gain_sel = prod[39:16];
      end else if (gain_sum[24]) begin
         gain_sel = msgd_pkg::GAIN_MAX;
      end else begin
         gain_sel = gain_sum[23:0];
      end
      gain_clamp = (gain_sel < gain_low_ff) ? gain_low_ff : gain_sel;
      if (gain_clamp > gain_high_ff) begin
         gain_clamp = gain_high_ff;
      end
   end

   assign w_new = msgd_pkg::sat32($signed({{26{w_ff[31]}}, w_ff})
                                  + $signed({{26{v_ff[31]}}, v_ff}));

   // end-of-batch schedule step
   always_comb begin
      rate_dec = (prod[56:33] != '0) ? msgd_pkg::Q17_MAX : prod[32:16];
      rate_new = (rate_dec < rate_floor_ff) ? rate_floor_ff : rate_dec;
      mom_sum  = {1'b0, cur_mom_ff} + {2'b0, momentum_step_ff};
      mom_sat  = mom_sum[17] ? msgd_pkg::Q17_MAX : mom_sum[16:0];
      mom_new  = (mom_sat > momentum_cap_ff) ? momentum_cap_ff : mom_sat;
   end

   // multiplier operand selection
   always_comb begin
      mul_a = v_ff;
      mul_b = $signed({8'b0, cur_mom_ff});
      case (state_ff)
         S_GAIN_MUL: begin
            mul_a = $signed({8'b0, gn_ff});
            mul_b = $signed({9'b0, msgd_pkg::GAIN_MUL});
         end
         S_GSCALE: begin
            mul_a = g_ff;
            mul_b = $signed({1'b0, gn_ff});
         end
         S_RG: begin
            mul_a = g_ff;
            mul_b = $signed({8'b0, cur_rate_ff});
         end
         S_RATE_MUL: begin
            mul_a = $signed({15'b0, cur_rate_ff});
            mul_b = $signed({8'b0, rate_decay_ff});
         end
         default: begin
            mul_a = v_ff;
            mul_b = $signed({8'b0, cur_mom_ff});
         end
      endcase
   end

   // memory write: load in idle, read-modify-write at the weight step
   always_comb begin
      st_wr_en   = 1'b0;
      st_wr_addr = addr_ff;
      st_wr_data = '{weight: w_new, velocity: v_ff, gain: gn_ff};
      if (req_xfer && (req_data.action == msgd_pkg::ACT_LOAD) && req_ok) begin
         st_wr_en   = 1'b1;
         st_wr_addr = req_addr;
         st_wr_data = '{weight: req_data.value, velocity: 32'sd0, gain: msgd_pkg::ONE_Q16};
      end else if (state_ff == S_WGT) begin
         st_wr_en = 1'b1;
      end
   end

   assign st_rd_en = req_xfer && req_ok
                     && (req_data.action inside {msgd_pkg::ACT_GRAD, msgd_pkg::ACT_READ});

   // configuration registers
   always_comb begin
      learning_rate_in  = learning_rate_ff;
      rate_decay_in     = rate_decay_ff;
      rate_floor_in     = rate_floor_ff;
      momentum_start_in = momentum_start_ff;
      momentum_step_in  = momentum_step_ff;
      momentum_cap_in   = momentum_cap_ff;
      gain_low_in       = gain_low_ff;
      gain_high_in      = gain_high_ff;
      if (csr_we) begin
         case (csr_index)
            msgd_pkg::CSR_LEARNING_RATE:  learning_rate_in  = csr_wdata[16:0];
            msgd_pkg::CSR_RATE_DECAY:     rate_decay_in     = csr_wdata[16:0];
            msgd_pkg::CSR_RATE_FLOOR:     rate_floor_in     = csr_wdata[16:0];
            msgd_pkg::CSR_MOMENTUM_START: momentum_start_in = csr_wdata[15:0];
            msgd_pkg::CSR_MOMENTUM_STEP:  momentum_step_in  = csr_wdata[15:0];
            msgd_pkg::CSR_MOMENTUM_CAP:   momentum_cap_in   = csr_wdata[16:0];
            msgd_pkg::CSR_GAIN_LOW:       gain_low_in       = csr_wdata[23:0];
            msgd_pkg::CSR_GAIN_HIGH:      gain_high_in      = csr_wdata[23:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cur_rate_in  = cur_rate_ff;
      cur_mom_in   = cur_mom_ff;
      act_in       = act_ff;
      last_in      = last_ff;
      ok_in        = ok_ff;
      addr_in      = addr_ff;
      g_in         = g_ff;
      w_in         = w_ff;
      v_in         = v_ff;
      gn_in        = gn_ff;
      acc_in       = acc_ff;
      res_w_in     = res_w_ff;
      res_l_in     = res_l_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               act_in   = req_data.action;
               last_in  = req_data.is_last;
               ok_in    = req_ok;
               addr_in  = req_addr;
               g_in     = req_data.value;
               res_w_in = 32'sd0;
               res_l_in = 32'sd0;
               case (req_data.action)
                  msgd_pkg::ACT_LOAD: begin
                     if (req_ok) begin
                        res_w_in = req_data.value;
                        res_l_in = req_data.value;
                     end
                     state_in = S_DONE;
                  end
                  msgd_pkg::ACT_GRAD: begin
                     if (req_ok) begin
                        state_in = S_FETCH;
                     end else if (req_data.is_last) begin
                        state_in = S_RATE_MUL;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  msgd_pkg::ACT_READ: begin
                     state_in = req_ok ? S_FETCH : S_DONE;
                  end
                  default: begin
                     cur_rate_in = learning_rate_ff;
                     cur_mom_in  = {1'b0, momentum_start_ff};
                     state_in    = S_DONE;
                  end
               endcase
            end
         end
         S_FETCH: begin
            w_in     = st_rd_data.weight;
            v_in     = st_rd_data.velocity;
            gn_in    = st_rd_data.gain;
            res_w_in = st_rd_data.weight;
            if (act_ff == msgd_pkg::ACT_READ) begin
               state_in = S_LA_MUL;
            end else begin
               state_in = gains_on ? S_GAIN_MUL : S_MV;
            end
         end
         S_GAIN_MUL: begin
            state_in = S_GAIN;
         end
         S_GAIN: begin
            gn_in    = gain_clamp;
            state_in = S_GSCALE;
         end
         S_GSCALE: begin
            state_in = S_GSAT;
         end
         S_GSAT: begin
            g_in     = msgd_pkg::sat32(prod_sh);
            state_in = S_MV;
         end
         S_MV: begin
            state_in = S_RG;
         end
         S_RG: begin
            // keep momentum term while the rate term is formed
            acc_in   = prod_ext;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            acc_in   = acc_ff - prod_ext;
            state_in = S_VEL;
         end
         S_VEL: begin
            v_in     = msgd_pkg::sat32(acc_ff >>> 16);
            state_in = S_WGT;
         end
         S_WGT: begin
            w_in     = w_new;
            res_w_in = w_new;
            state_in = last_ff ? S_RATE_MUL : S_LA_MUL;
         end
         S_RATE_MUL: begin
            state_in = S_SCHED;
         end
         S_SCHED: begin
            cur_rate_in = rate_new;
            cur_mom_in  = mom_new;
            state_in    = ok_ff ? S_LA_MUL : S_DONE;
         end
         S_LA_MUL: begin
            state_in = S_LA;
         end
         S_LA: begin
            res_l_in = msgd_pkg::sat32($signed({{26{w_ff[31]}}, w_ff}) + prod_sh);
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{weight_out: res_w_ff, lookahead_out: res_l_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         rsp_valid_ff      <= 1'b0;
         learning_rate_ff  <= 17'd6554;
         rate_decay_ff     <= 17'd65536;
         rate_floor_ff     <= 17'd0;
         momentum_start_ff <= 16'd0;
         momentum_step_ff  <= 16'd0;
         momentum_cap_ff   <= 17'd65536;
         gain_low_ff       <= msgd_pkg::ONE_Q16;
         gain_high_ff      <= msgd_pkg::ONE_Q16;
         cur_rate_ff       <= 17'd6554;
         cur_mom_ff        <= 17'd0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         learning_rate_ff  <= learning_rate_in;
         rate_decay_ff     <= rate_decay_in;
         rate_floor_ff     <= rate_floor_in;
         momentum_start_ff <= momentum_start_in;
         momentum_step_ff  <= momentum_step_in;
         momentum_cap_ff   <= momentum_cap_in;
         gain_low_ff       <= gain_low_in;
         gain_high_ff      <= gain_high_in;
         cur_rate_ff       <= cur_rate_in;
         cur_mom_ff        <= cur_mom_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      last_ff     <= last_in;
      ok_ff       <= ok_in;
      addr_ff     <= addr_in;
      g_ff        <= g_in;
      w_ff        <= w_in;
      v_ff        <= v_in;
      gn_ff       <= gn_in;
      acc_ff      <= acc_in;
      res_w_ff    <= res_w_in;
      res_l_ff    <= res_l_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a new result only ever comes out of the final sequencer step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside the final step");

   // the block is busy right after taking an item
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block ready again straight after a transfer");

   // the memory is written only by a load or at the weight step
   a_store_write: assert property (@(posedge clock) disable iff (reset)
      st_wr_en |-> (state_ff == S_WGT) || req_xfer)
      else $error("unexpected memory write");

   // a decayed rate never falls below the floor in force
   a_rate_floor: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCHED |=> cur_rate_ff >= $past(rate_floor_ff))
      else $error("rate below floor after schedule step");

endmodule

// ===== tb/momentum_sgd_gain_update_test.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// momentum_sgd_gain_update_test
// Self-checking bench for the momentum SGD gain update block. A queue of
// requests feeds a valid/ready driver, each accepted request runs through a
// fixed point model of the optimiser, and a monitor compares every response
// field with the oldest predicted one. Directed corner cases come first, then
// randomised phases under several register settings and handshake loads.
// -----------------------------------------------------------------------------
module momentum_sgd_gain_update_test;

   localparam int     NUM         = 1024;
   localparam longint UNITY       = 65536;
   localparam longint GAIN_STEP   = 3277;
   localparam longint GAIN_SHRINK = 62259;
   localparam longint GAIN_TOP    = 64'hFFFFFF;
   localparam longint Q17_TOP     = 64'h1FFFF;
   localparam longint S32_MAX     = 64'sh7FFFFFFF;
   localparam longint S32_MIN     = -64'sh80000000;
   localparam int     TAIL_CYCLES = 20;

   typedef enum {SET_RANDOM, SET_TOP, SET_BOTTOM, SET_CROSSED, SET_NO_GAIN} setting_kind_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   msgd_pkg::req_type              req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   msgd_pkg::rsp_type              rsp_data;
   logic                           csr_we = 1'b0;
   logic [msgd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [msgd_pkg::CSR_W-1:0]     csr_wdata = '0;

   // optimiser state as the block should hold it
   logic signed [31:0] weight_mem [NUM];
   logic signed [31:0] velocity_mem [NUM];
   logic [23:0]        gain_mem [NUM];
   longint cfg_rate = 6554, cfg_decay = 65536, cfg_floor = 0, cfg_mstart = 0;
   longint cfg_mstep = 0, cfg_mcap = 65536, cfg_glow = 65536, cfg_ghigh = 65536;
   longint rate_now = 6554, mom_now = 0;

   msgd_pkg::req_type req_backlog [$];
   msgd_pkg::rsp_type rsp_due [$];
   msgd_pkg::rsp_type rsp_want;
   int      hot_idx [$];

   int errors = 0;
   int results_seen = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   bit send_pause = 1'b0;
   bit req_sent = 1'b0;

   momentum_sgd_gain_update #(.NUM_WEIGHTS(NUM)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic signed [31:0] clip32(input longint x);
      if (x > S32_MAX) return 32'sh7FFFFFFF;
      if (x < S32_MIN) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] lookahead_of(input logic signed [31:0] w,
                                                       input logic signed [31:0] v);
      return clip32(longint'(w) + ((mom_now * longint'(v)) >>> 16));
   endfunction

   task automatic compute_weight_update(input msgd_pkg::req_type it);
      logic signed [31:0] w, v, wo, lo;
      longint g, gn, r, m;
      logic opposite;
      int i;
      i = int'(it.index);
      wo = '0;
      lo = '0;
      case (it.action)
         msgd_pkg::ACT_LOAD: begin
            weight_mem[i] = it.value;
            velocity_mem[i] = '0;
            gain_mem[i] = 24'(UNITY);
            wo = it.value;
            lo = it.value;
         end
         msgd_pkg::ACT_GRAD: begin
            w = weight_mem[i];
            v = velocity_mem[i];
            g = longint'($signed(it.value));
            // gains are bypassed while both bounds sit at 1.0
            if (cfg_glow != UNITY || cfg_ghigh != UNITY) begin
               gn = longint'(gain_mem[i]);
               opposite = (v < 0 && g > 0) || (v > 0 && g < 0);
               if (!opposite) begin
                  gn = gn + GAIN_STEP;
                  if (gn > GAIN_TOP) gn = GAIN_TOP;
               end else begin
                  gn = (gn * GAIN_SHRINK) >>> 16;
               end
               if (gn < cfg_glow) gn = cfg_glow;
               if (gn > cfg_ghigh) gn = cfg_ghigh;
               gain_mem[i] = gn[23:0];
               g = clip32((g * gn) >>> 16);
            end
            v = clip32((mom_now * longint'(v) - rate_now * g) >>> 16);
            w = clip32(longint'(w) + longint'(v));
            velocity_mem[i] = v;
            weight_mem[i] = w;
            wo = w;
            if (it.is_last) begin
               r = (rate_now * cfg_decay) >>> 16;
               if (r > Q17_TOP) r = Q17_TOP;
               if (r < cfg_floor) r = cfg_floor;
               rate_now = r;
               m = mom_now + cfg_mstep;
               if (m > Q17_TOP) m = Q17_TOP;
               if (m > cfg_mcap) m = cfg_mcap;
               mom_now = m;
            end
            // lookahead sees the schedule after this element
            lo = lookahead_of(w, v);
         end
         msgd_pkg::ACT_READ: begin
            wo = weight_mem[i];
            lo = lookahead_of(weight_mem[i], velocity_mem[i]);
         end
         msgd_pkg::ACT_RESTART: begin
            rate_now = cfg_rate;
            mom_now = cfg_mstart;
         end
         default: ;
      endcase
      rsp_due.push_back('{weight_out: wo, lookahead_out: lo});
   endtask

   task automatic flag_mismatch(input string msg);
      errors++;
      $display("mismatch at result %0d: %s", results_seen, msg);
   endtask

   // driver: a new request goes out only once the previous one has transferred
   always @(posedge clock) begin
      if (req_valid && req_ready) begin
         compute_weight_update(req_data);
         req_sent = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_sent) begin
         req_sent = 1'b0;
         if (!send_pause && req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected response %h", rsp_data));
         end else begin
            rsp_want = rsp_due.pop_front();
            if (rsp_data.weight_out !== rsp_want.weight_out)
               flag_mismatch($sformatf("weight_out %h, want %h",
                                       rsp_data.weight_out, rsp_want.weight_out));
            if (rsp_data.lookahead_out !== rsp_want.lookahead_out)
               flag_mismatch($sformatf("lookahead_out %h, want %h",
                                       rsp_data.lookahead_out, rsp_want.lookahead_out));
         end
      end
   end

   task automatic queue_req(input logic [1:0] act, input int idx, input logic signed [31:0] val,
                            input logic last);
      req_backlog.push_back('{action: act, index: idx[9:0], value: val, is_last: last});
   endtask

   task automatic write_csr(input logic [msgd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [msgd_pkg::CSR_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         msgd_pkg::CSR_LEARNING_RATE:  cfg_rate = val[16:0];
         msgd_pkg::CSR_RATE_DECAY:     cfg_decay = val[16:0];
         msgd_pkg::CSR_RATE_FLOOR:     cfg_floor = val[16:0];
         msgd_pkg::CSR_MOMENTUM_START: cfg_mstart = val[15:0];
         msgd_pkg::CSR_MOMENTUM_STEP:  cfg_mstep = val[15:0];
         msgd_pkg::CSR_MOMENTUM_CAP:   cfg_mcap = val[16:0];
         msgd_pkg::CSR_GAIN_LOW:       cfg_glow = val[23:0];
         msgd_pkg::CSR_GAIN_HIGH:      cfg_ghigh = val[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // block idle: nothing queued, nothing offered, nothing outstanding
   task automatic wait_idle();
      do @(posedge clock); while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [31:0] extreme_value();
      case ($urandom_range(4))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'sh0;
         3: return 32'sh1;
         default: return -32'sh1;
      endcase
   endfunction

   function automatic logic signed [31:0] grad_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 50) return int'($urandom_range(262143)) - 131072;
      if (sel < 75) return int'($urandom_range(33554431)) - 16777216;
      if (sel < 90) return $urandom;
      return extreme_value();
   endfunction

   function automatic logic signed [31:0] weight_value();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 40) return int'($urandom_range(2097151)) - 1048576;
      if (sel < 80) return $urandom;
      return extreme_value();
   endfunction

   task automatic apply_setting(input setting_kind_type kind);
      logic [msgd_pkg::CSR_W-1:0] lr, decay, floor_v, mstart, mstep, mcap, glow, ghigh;
      lr = msgd_pkg::CSR_W'($urandom_range(1, 65536));
      decay = ($urandom_range(3) == 0) ? msgd_pkg::CSR_W'($urandom_range(1, 65536))
                                       : msgd_pkg::CSR_W'($urandom_range(49152, 65536));
      floor_v = msgd_pkg::CSR_W'($urandom_range(0, 8192));
      mstart = msgd_pkg::CSR_W'($urandom_range(0, 65535));
      mstep = msgd_pkg::CSR_W'($urandom_range(0, 8192));
      mcap = msgd_pkg::CSR_W'($urandom_range(0, 65536));
      case ($urandom_range(4))
         0: begin
            glow = msgd_pkg::CSR_W'(UNITY);
            ghigh = msgd_pkg::CSR_W'(UNITY);
         end
         1: begin
            glow = msgd_pkg::CSR_W'($urandom_range(0, 16777215));
            ghigh = msgd_pkg::CSR_W'($urandom_range(0, 16777215));
         end
         default: begin
            glow = msgd_pkg::CSR_W'($urandom_range(0, 65536));
            ghigh = msgd_pkg::CSR_W'($urandom_range(65536, 4194303));
         end
      endcase
      case (kind)
         SET_TOP: begin
            lr = 24'd65536; decay = 24'd65536; floor_v = 24'd65536; mstart = 24'd65535;
            mstep = 24'd65535; mcap = 24'd65536; glow = 24'd0; ghigh = 24'hFFFFFF;
         end
         SET_BOTTOM: begin
            lr = 24'd1; decay = 24'd1; floor_v = 24'd0; mstart = 24'd0; mstep = 24'd0;
            mcap = 24'd0; glow = 24'd0; ghigh = 24'd0;
         end
         SET_CROSSED: begin
            glow = 24'hFFFFFF;
            ghigh = msgd_pkg::CSR_W'($urandom_range(0, 131072));
         end
         SET_NO_GAIN: begin
            glow = msgd_pkg::CSR_W'(UNITY);
            ghigh = msgd_pkg::CSR_W'(UNITY);
         end
         default: ;
      endcase
      write_csr(msgd_pkg::CSR_LEARNING_RATE, lr);
      write_csr(msgd_pkg::CSR_RATE_DECAY, decay);
      write_csr(msgd_pkg::CSR_RATE_FLOOR, floor_v);
      write_csr(msgd_pkg::CSR_MOMENTUM_START, mstart);
      write_csr(msgd_pkg::CSR_MOMENTUM_STEP, mstep);
      write_csr(msgd_pkg::CSR_MOMENTUM_CAP, mcap);
      write_csr(msgd_pkg::CSR_GAIN_LOW, glow);
      write_csr(msgd_pkg::CSR_GAIN_HIGH, ghigh);
   endtask

   task automatic queue_random_item();
      int unsigned sel;
      int idx;
      sel = $urandom_range(99);
      idx = hot_idx[$urandom_range(hot_idx.size() - 1)];
      if (sel < 62) begin
         queue_req(msgd_pkg::ACT_GRAD, idx, grad_value(), $urandom_range(7) == 0);
      end else if (sel < 77) begin
         queue_req(msgd_pkg::ACT_READ, idx, $urandom, 1'($urandom_range(1)));
      end else if (sel < 95) begin
         // stray loads anywhere in the memory, plus reloads of the working set
         if ($urandom_range(1)) idx = int'($urandom_range(NUM - 1));
         queue_req(msgd_pkg::ACT_LOAD, idx, weight_value(), 1'($urandom_range(1)));
      end else begin
         queue_req(msgd_pkg::ACT_RESTART, int'($urandom_range(NUM - 1)), $urandom,
                   1'($urandom_range(1)));
      end
   endtask

   task automatic run_phase(input setting_kind_type kind, input int items, input int send_idle,
                            input int recv_stall, input bit restart, input bit hold,
                            input bit pause);
      int done, len, idx;
      bit neg;
      logic signed [31:0] mag;
      wait_idle();
      apply_setting(kind);
      send_idle_pct = send_idle;
      rsp_stall_pct = recv_stall;
      if (restart) queue_req(msgd_pkg::ACT_RESTART, int'($urandom_range(NUM - 1)), $urandom,
                             1'($urandom_range(1)));
      hot_idx.delete();
      repeat (10) hot_idx.push_back(int'($urandom_range(NUM - 1)));
      if ($urandom_range(1)) hot_idx.push_back(0);
      if ($urandom_range(1)) hot_idx.push_back(NUM - 1);
      foreach (hot_idx[k]) queue_req(msgd_pkg::ACT_LOAD, hot_idx[k], weight_value(),
                                     1'($urandom_range(1)));
      if (hold) begin
         // receiver holds off while the sender keeps offering
         @(posedge clock);
         rsp_hold_left = 300;
      end
      done = 0;
      while (done < items) begin
         if ($urandom_range(3) == 0) begin
            // run of same-sign gradients on one weight so the gain climbs, then may flip
            idx = hot_idx[$urandom_range(hot_idx.size() - 1)];
            neg = 1'($urandom_range(1));
            len = int'($urandom_range(3, 8));
            for (int j = 0; j < len; j++) begin
               mag = $urandom_range(1, 262144);
               if (j == len - 1 && $urandom_range(2) == 0) neg = !neg;
               queue_req(msgd_pkg::ACT_GRAD, idx, neg ? -mag : mag,
                         (j == len - 1) && $urandom_range(1));
            end
            done += len;
         end else begin
            queue_random_item();
            done++;
         end
      end
      if (pause) begin
         do @(posedge clock); while (req_backlog.size() > items / 2);
         send_pause = 1'b1;
         do @(posedge clock); while (req_valid || rsp_due.size() != 0);
         send_pause = 1'b0;
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: gains off at reset values
      queue_req(msgd_pkg::ACT_LOAD, 0, 32'sh7FFFFFFF, 1'b0);
      queue_req(msgd_pkg::ACT_LOAD, NUM - 1, 32'sh80000000, 1'b1);
      queue_req(msgd_pkg::ACT_LOAD, 5, 32'sh00010000, 1'b0);
      queue_req(msgd_pkg::ACT_LOAD, 6, 32'sh0, 1'b0);
      queue_req(msgd_pkg::ACT_GRAD, 0, 32'sh7FFFFFFF, 1'b0);
      queue_req(msgd_pkg::ACT_GRAD, NUM - 1, 32'sh80000000, 1'b1);
      queue_req(msgd_pkg::ACT_GRAD, 5, -32'sh00010000, 1'b0);
      queue_req(msgd_pkg::ACT_READ, 0, 32'sh0, 1'b0);
      queue_req(msgd_pkg::ACT_READ, NUM - 1, 32'shFFFFFFFF, 1'b1);
      queue_req(msgd_pkg::ACT_READ, 5, 32'sh0, 1'b0);
      queue_req(msgd_pkg::ACT_RESTART, 0, 32'sh0, 1'b1);
      wait_idle();

      // gains on, full range, schedule at its top
      apply_setting(SET_TOP);
      queue_req(msgd_pkg::ACT_RESTART, NUM - 1, 32'sh7FFFFFFF, 1'b0);
      queue_req(msgd_pkg::ACT_GRAD, 5, 32'sh00010000, 1'b0);
      queue_req(msgd_pkg::ACT_GRAD, 5, -32'sh7FFFFFFF, 1'b1);
      queue_req(msgd_pkg::ACT_GRAD, 6, 32'sh0, 1'b1);
      queue_req(msgd_pkg::ACT_GRAD, 0, 32'sh80000000, 1'b1);
      queue_req(msgd_pkg::ACT_READ, 6, 32'sh0, 1'b0);
      wait_idle();

      // both bounds at the gain ceiling: growth saturates
      write_csr(msgd_pkg::CSR_GAIN_LOW, 24'hFFFFFF);
      write_csr(msgd_pkg::CSR_GAIN_HIGH, 24'hFFFFFF);
      queue_req(msgd_pkg::ACT_GRAD, 5, 32'sh1, 1'b0);
      queue_req(msgd_pkg::ACT_GRAD, 5, 32'sh1, 1'b0);
      wait_idle();

      // crossed bounds: upper bound wins
      write_csr(msgd_pkg::CSR_GAIN_HIGH, 24'h008000);
      queue_req(msgd_pkg::ACT_GRAD, 5, -32'sh1, 1'b1);
      queue_req(msgd_pkg::ACT_READ, 5, 32'sh0, 1'b0);
      queue_req(msgd_pkg::ACT_RESTART, 5, 32'sh0, 1'b0);
      queue_req(msgd_pkg::ACT_LOAD, NUM - 1, 32'sh55555555, 1'b0);

      run_phase(SET_RANDOM, 120, 0, 0, 1'b1, 1'b1, 1'b0);
      run_phase(SET_TOP, 120, 69, 0, 1'b0, 1'b0, 1'b0);
      run_phase(SET_BOTTOM, 120, 0, 69, 1'b1, 1'b0, 1'b0);
      run_phase(SET_CROSSED, 120, 13, 13, 1'b0, 1'b0, 1'b1);
      run_phase(SET_NO_GAIN, 120, 0, 0, 1'b1, 1'b0, 1'b0);
      run_phase(SET_RANDOM, 120, 69, 0, 1'b1, 1'b1, 1'b0);
      run_phase(SET_RANDOM, 120, 0, 69, 1'b0, 1'b0, 1'b1);
      run_phase(SET_RANDOM, 120, 13, 13, 1'b1, 1'b0, 1'b0);
      wait_idle();

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/msgd_pkg.sv
hw/rtl/msgd_mul.sv
hw/rtl/msgd_store.sv
hw/rtl/momentum_sgd_gain_update.sv
tb/momentum_sgd_gain_update_test.sv
